// ----- rtl/core/x87fc_pkg.sv -----
package x87fc_pkg;

   localparam logic [2:0] KIND_S2X = 3'd0;
   localparam logic [2:0] KIND_D2X = 3'd1;
   localparam logic [2:0] KIND_X2S = 3'd2;
   localparam logic [2:0] KIND_X2D = 3'd3;
   localparam logic [2:0] KIND_X2I = 3'd4;
   localparam logic [2:0] KIND_I2X = 3'd5;

   localparam logic [1:0] MODE_NEAREST = 2'd0;
   localparam logic [1:0] MODE_DOWN    = 2'd1;
   localparam logic [1:0] MODE_UP      = 2'd2;
   localparam logic [1:0] MODE_CHOP    = 2'd3;

   localparam logic [14:0] EXT_BIAS = 15'd16383;
   localparam logic [14:0] SGL_BIAS = 15'd127;
   localparam logic [14:0] DBL_BIAS = 15'd1023;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] raw_word;
      logic [15:0] ext_sign_exponent;
      logic [63:0] ext_mantissa;
      logic        int_negative;
   } req_type;

   typedef struct packed {
      logic [63:0] result_word;
      logic [15:0] result_sign_exponent;
      logic [63:0] result_mantissa;
      logic        result_negative;
      logic        overflow;
   } rsp_type;

endpackage

// ----- rtl/core/x87fc_lzc.sv -----
module x87fc_lzc
   import x87fc_pkg::*;
(
   input  logic [63:0] value,
   output logic [5:0]  count
);
   logic [7:0]       grp_nz;
   logic [7:0][2:0]  grp_cnt;
   logic [2:0]       top;

   always_comb begin
      for (int g = 0; g < 8; g++) begin
         grp_nz[g] = |value[g*8 +: 8];
         grp_cnt[g] = 3'd0;
         for (int b = 0; b < 8; b++) begin
            if (value[g*8 + b]) begin
               grp_cnt[g] = 3'(7 - b);
            end
         end
      end
      top = 3'd0;
      for (int g = 0; g < 8; g++) begin
         if (grp_nz[g]) begin
            top = 3'(7 - g);
         end
      end
      count = {top, grp_cnt[3'(7) - top]};
   end
endmodule

// ----- rtl/core/x87_format_converter.sv -----
// Throughput: one operand per cycle; busy stays low, so start is taken every cycle.
// Three register stages: zero count, rounding decision, increment and packing.
// Reset clears the stage valid bits and sets the rounding mode to nearest.
module x87_format_converter
   import x87fc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data
);
   logic [1:0] mode_ff;

   // stage 1 registers
   logic       v1_ff;
   req_type    r1_ff;
   logic [1:0] m1_ff;
   logic [5:0] lz1_ff;
   logic [5:0] lz_in;

   // stage 2 registers
   logic        v2_ff;
   logic [2:0]  k2_ff;
   logic [63:0] w2_ff, w2_in;
   logic [15:0] se2_ff, se2_in;
   logic [63:0] m2_ff, m2_in;
   logic        neg2_ff, neg2_in;
   logic        ovf2_ff, ovf2_in;
   logic        inc2_ff, inc2_in;

   // stage 3 registers
   logic        v3_ff;
   rsp_type     r3_ff, r3_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   x87fc_lzc u_lzc (.value(req_data.raw_word), .count(lz_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NEAREST;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            mode_ff <= csr_data;
         end
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      r1_ff   <= req_data;
      m1_ff   <= mode_ff;
      lz1_ff  <= lz_in;
      k2_ff   <= r1_ff.kind;
      w2_ff   <= w2_in;
      se2_ff  <= se2_in;
      m2_ff   <= m2_in;
      neg2_ff <= neg2_in;
      ovf2_ff <= ovf2_in;
      inc2_ff <= inc2_in;
      r3_ff   <= r3_in;
   end

   // stage 2: form converted or truncated result and rounding decision
   logic [14:0] e;
   logic        sgn;
   logic [31:0] s;
   logic [63:0] man;
   logic [15:0] shift;
   logic [63:0] v;
   logic [31:0] under;
   logic [7:0]  low8;
   logic [10:0] low11;
   logic [32:0] sum;

   always_comb begin
      e     = r1_ff.ext_sign_exponent[14:0];
      sgn   = r1_ff.ext_sign_exponent[15];
      man   = r1_ff.ext_mantissa;
      s     = r1_ff.raw_word[31:0];
      low8  = man[39:32];
      low11 = man[10:0];
      shift = 16'(EXT_BIAS) + 16'd63 - {1'b0, e};
      v     = '0;
      under = '0;
      sum   = '0;
      w2_in = '0;
      se2_in = '0;
      m2_in = '0;
      neg2_in = 1'b0;
      ovf2_in = 1'b0;
      inc2_in = 1'b0;
      case (r1_ff.kind)
         KIND_S2X: begin
            if (s[30:0] != 31'd0) begin
               se2_in = {s[31], 15'({7'd0, s[30:23]} + EXT_BIAS - SGL_BIAS)};
               m2_in  = {1'b1, s[22:0], 40'd0};
            end else begin
               se2_in = {s[31], 15'd0};
            end
         end
         KIND_D2X: begin
            if (r1_ff.raw_word[62:0] != 63'd0) begin
               se2_in = {r1_ff.raw_word[63],
                         15'({4'd0, r1_ff.raw_word[62:52]} + EXT_BIAS - DBL_BIAS)};
               m2_in  = {1'b1, r1_ff.raw_word[51:0], 11'd0};
            end else begin
               se2_in = {r1_ff.raw_word[63], 15'd0};
            end
         end
         KIND_X2S: begin
            if (e == 15'd0) begin
               w2_in = {32'd0, sgn, 31'd0};
            end else begin
               w2_in = {32'd0, sgn, 8'(e + SGL_BIAS - EXT_BIAS), man[62:40]};
               case (m1_ff)
                  MODE_NEAREST: inc2_in = low8 > 8'h80;
                  MODE_DOWN:    inc2_in = sgn && (low8 != 8'd0);
                  MODE_UP:      inc2_in = !sgn && (low8 != 8'd0);
                  default:      inc2_in = 1'b0;
               endcase
            end
         end
         KIND_X2D: begin
            if (e == 15'd0) begin
               w2_in = {sgn, 63'd0};
            end else begin
               w2_in = {sgn, 11'(e + DBL_BIAS - EXT_BIAS), man[62:11]};
               case (m1_ff)
                  MODE_NEAREST: inc2_in = low11 > 11'h400;
                  MODE_DOWN:    inc2_in = sgn && (low11 != 11'd0);
                  MODE_UP:      inc2_in = !sgn && (low11 != 11'd0);
                  default:      inc2_in = 1'b0;
               endcase
            end
         end
         KIND_X2I: begin
            neg2_in = sgn;
            if (shift[15]) begin
               ovf2_in = 1'b1;
            end else if (shift < 16'd96) begin
               v = (shift < 16'd64) ? (man >> shift[5:0]) : 64'd0;
               if (shift == 16'd0) begin
                  under = '0;
               end else if (shift <= 16'd32) begin
                  under = 32'(man << (7'd32 - shift[6:0]));
               end else begin
                  under = 32'(man >> (7'(shift[6:0]) - 7'd32));
               end
               w2_in = v;
               sum = {1'b0, under} + 33'h7fffffff + {32'd0, v[0]};
               case (m1_ff)
                  MODE_NEAREST: inc2_in = sum[32];
                  MODE_DOWN:    inc2_in = sgn && (under != 32'd0);
                  MODE_UP:      inc2_in = !sgn && (under != 32'd0);
                  default:      inc2_in = 1'b0;
               endcase
            end
         end
         KIND_I2X: begin
            if (r1_ff.raw_word != 64'd0) begin
               se2_in = {r1_ff.int_negative, EXT_BIAS + 15'd63 - 15'(lz1_ff)};
               m2_in  = r1_ff.raw_word << lz1_ff;
            end
         end
         default: ;
      endcase
   end

   // stage 3: apply increment and pack
   always_comb begin
      r3_in = '0;
      r3_in.result_sign_exponent = se2_ff;
      r3_in.result_mantissa      = m2_ff;
      r3_in.result_negative      = neg2_ff;
      r3_in.overflow             = ovf2_ff;
      if (k2_ff == KIND_X2S) begin
         r3_in.result_word = {32'd0, w2_ff[31:0] + 32'(inc2_ff)};
      end else begin
         r3_in.result_word = w2_ff + 64'(inc2_ff);
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = r3_ff;
endmodule

// ----- rtl/core/x87fc_checker.sv -----
module x87fc_checker
   import x87fc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);
   a_lat: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_valid) else $error("result lost");
   a_none: assert property (@(posedge clock) disable iff (reset)
      !$past(start, 3) |-> !rsp_valid) else $error("spurious result");
   a_ovf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |-> rsp_data.result_word == 64'd0)
      else $error("overflow with nonzero word");
endmodule

bind x87_format_converter x87fc_checker u_chk (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_data(rsp_data)
);

// ----- dv/x87_format_converter_tb.sv -----
module x87_format_converter_tb;
   import x87fc_pkg::*;

   localparam int LATENCY     = 3;
   localparam int CYCLE_LIMIT = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   req_type    req_data = '0;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_data = MODE_NEAREST;

   logic [1:0] mode_q;
   rsp_type    pending_conversions[$];
   int         mismatches = 0;
   int         cycle_count = 0;

   typedef struct {
      req_type req;
      logic    known;
      rsp_type want;
   } vector_row_type;

   vector_row_type vectors[$];

   x87_format_converter u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   function automatic logic want_increment(logic [1:0] md, logic neg, logic nonzero,
                                           logic near_up);
      case (md)
         MODE_NEAREST: want_increment = near_up;
         MODE_DOWN:    want_increment = neg && nonzero;
         MODE_UP:      want_increment = !neg && nonzero;
         default:      want_increment = 1'b0;
      endcase
   endfunction

   function automatic rsp_type convert(req_type rq, logic [1:0] md);
      rsp_type     r;
      logic [31:0] sgl;
      logic [63:0] dbl, mag, v;
      logic [14:0] ex;
      logic [31:0] under;
      logic        neg;
      int          shift;
      r = '0;
      ex = rq.ext_sign_exponent[14:0];
      neg = rq.ext_sign_exponent[15];
      case (rq.kind)
         KIND_S2X: begin
            sgl = rq.raw_word[31:0];
            if (sgl[30:0] == 0) begin
               r.result_sign_exponent = {sgl[31], 15'd0};
            end else begin
               r.result_sign_exponent = {sgl[31], 15'(sgl[30:23] + EXT_BIAS - SGL_BIAS)};
               r.result_mantissa = {1'b1, sgl[22:0], 40'd0};
            end
         end
         KIND_D2X: begin
            dbl = rq.raw_word;
            if (dbl[62:0] == 0) begin
               r.result_sign_exponent = {dbl[63], 15'd0};
            end else begin
               r.result_sign_exponent = {dbl[63], 15'(dbl[62:52] + EXT_BIAS - DBL_BIAS)};
               r.result_mantissa = {1'b1, dbl[51:0], 11'd0};
            end
         end
         KIND_X2S: begin
            if (ex == 0) begin
               r.result_word = (rq.ext_sign_exponent != 0) ? 64'h8000_0000 : 64'd0;
            end else begin
               sgl = {neg, 8'(ex + SGL_BIAS - EXT_BIAS), rq.ext_mantissa[62:40]};
               if (want_increment(md, neg, rq.ext_mantissa[39:32] != 0,
                                  rq.ext_mantissa[39:32] > 8'h80))
                  sgl = sgl + 32'd1;
               r.result_word = {32'd0, sgl};
            end
         end
         KIND_X2D: begin
            if (ex == 0) begin
               r.result_word = (rq.ext_sign_exponent != 0) ? 64'h8000_0000_0000_0000 : 64'd0;
            end else begin
               dbl = {neg, 11'(ex + DBL_BIAS - EXT_BIAS), rq.ext_mantissa[62:11]};
               if (want_increment(md, neg, rq.ext_mantissa[10:0] != 0,
                                  rq.ext_mantissa[10:0] > 11'h400))
                  dbl = dbl + 64'd1;
               r.result_word = dbl;
            end
         end
         KIND_X2I: begin
            shift = int'(EXT_BIAS) + 63 - int'(ex);
            r.result_negative = neg;
            if (shift < 0) begin
               r.overflow = 1'b1;
            end else if (shift < 96) begin
               mag = rq.ext_mantissa;
               v = (shift < 64) ? (mag >> shift) : 64'd0;
               if (shift == 0) under = 0;
               else if (shift <= 32) under = 32'(mag << (32 - shift));
               else under = 32'(mag >> (shift - 32));
               if (want_increment(md, neg, under != 0,
                                  ({1'b0, under} + 33'h7fff_ffff + v[0]) > 33'hffff_ffff))
                  v = v + 64'd1;
               r.result_word = v;
            end
         end
         KIND_I2X: begin
            mag = rq.raw_word;
            if (mag != 0) begin
               ex = EXT_BIAS + 15'd63;
               while (!mag[63]) begin
                  mag = mag << 1;
                  ex = ex - 15'd1;
               end
               r.result_sign_exponent = {rq.int_negative, ex};
               r.result_mantissa = mag;
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic req_type random_request();
      req_type rq;
      rq.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7))
                                             : 3'($urandom_range(0, 5));
      rq.raw_word = {$urandom, $urandom};
      rq.ext_mantissa = {$urandom, $urandom};
      rq.int_negative = 1'($urandom);
      case ($urandom_range(0, 4))
         0: rq.ext_sign_exponent = 16'($urandom);
         1: rq.ext_sign_exponent = {1'($urandom), 15'(16383 + $urandom_range(0, 70))};
         2: rq.ext_sign_exponent = {1'($urandom), 15'(16383 - 40 + $urandom_range(0, 140))};
         default: rq.ext_sign_exponent = {1'($urandom), 15'(16383 - 200 + $urandom_range(0, 400))};
      endcase
      case ($urandom_range(0, 5))
         0: rq.ext_mantissa[39:32] = 8'($urandom_range(127, 129));
         1: rq.ext_mantissa[10:0] = 11'($urandom_range(1023, 1025));
         2: rq.ext_mantissa[39:0] = '0;
         3: rq.raw_word = rq.raw_word >> $urandom_range(0, 63);
         default: ;
      endcase
      if ($urandom_range(0, 3) == 0) rq.ext_mantissa[62:40] = '1;
      return rq;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (!reset) begin
         if (csr_valid && csr_ready) mode_q <= csr_data;
         if (start && !busy) pending_conversions.push_back(convert(req_data, mode_q));
         if (rsp_valid) begin
            if (pending_conversions.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transfer %h", rsp_data);
            end else begin
               want = pending_conversions.pop_front();
               if (rsp_data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: word %h/%h se %h/%h man %h/%h neg %b/%b ovf %b/%b",
                              want.result_word, rsp_data.result_word,
                              want.result_sign_exponent, rsp_data.result_sign_exponent,
                              want.result_mantissa, rsp_data.result_mantissa,
                              want.result_negative, rsp_data.result_negative,
                              want.overflow, rsp_data.overflow);
               end
            end
         end
      end else begin
         mode_q <= MODE_NEAREST;
      end
   end

   task automatic send(req_type rq, bit gaps);
      if (gaps && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_conversions.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic set_mode(logic [1:0] md);
      csr_valid <= 1'b1;
      csr_data <= md;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_row(logic [2:0] k, logic [63:0] rw, logic [15:0] se, logic [63:0] man,
                          logic ineg, logic known, rsp_type want);
      vector_row_type row;
      row.req = '{kind: k, raw_word: rw, ext_sign_exponent: se, ext_mantissa: man,
                  int_negative: ineg};
      row.known = known;
      row.want = want;
      vectors.push_back(row);
   endtask

   initial begin
      rsp_type want;
      rsp_type none;
      none = '0;
      add_row(KIND_S2X, 64'h0, 16'h0, 64'h0, 1'b0, 1'b1, '0);
      add_row(KIND_S2X, 64'h8000_0000, 16'h0, 64'h0, 1'b0, 1'b1,
              '{64'd0, 16'h8000, 64'd0, 1'b0, 1'b0});
      add_row(KIND_S2X, 64'hffff_ffff_ffff_ffff, 16'h0, 64'h0, 1'b0, 1'b0, none);
      add_row(KIND_D2X, 64'h8000_0000_0000_0000, 16'h0, 64'h0, 1'b0, 1'b1,
              '{64'd0, 16'h8000, 64'd0, 1'b0, 1'b0});
      add_row(KIND_D2X, 64'h7fff_ffff_ffff_ffff, 16'h0, 64'h0, 1'b0, 1'b0, none);
      add_row(KIND_X2S, 64'h0, 16'h8000, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1,
              '{64'h8000_0000, 16'd0, 64'd0, 1'b0, 1'b0});
      add_row(KIND_X2S, 64'h0, 16'h3fff, 64'hffff_ff80_0000_0000, 1'b0, 1'b0, none);
      add_row(KIND_X2S, 64'h0, 16'hbfff, 64'hffff_ff81_0000_0000, 1'b0, 1'b0, none);
      add_row(KIND_X2D, 64'h0, 16'h0, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1, '0);
      add_row(KIND_X2D, 64'h0, 16'h43fe, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, none);
      add_row(KIND_X2D, 64'h0, 16'hc3fe, 64'hffff_ffff_ffff_f400, 1'b0, 1'b0, none);
      add_row(KIND_X2I, 64'h0, 16'h7fff, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b1,
              '{64'd0, 16'd0, 64'd0, 1'b0, 1'b1});
      add_row(KIND_X2I, 64'h0, 16'hc03e, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, none);
      add_row(KIND_X2I, 64'h0, 16'h3fff, 64'hc000_0000_0000_0000, 1'b0, 1'b0, none);
      add_row(KIND_X2I, 64'h0, 16'h3ffe, 64'h8000_0000_0000_0000, 1'b0, 1'b0, none);
      add_row(KIND_X2I, 64'h0, 16'h3fa0, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1,
              '{64'd0, 16'd0, 64'd0, 1'b0, 1'b0});
      add_row(KIND_X2I, 64'h0, 16'hbfbf, 64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, none);
      add_row(KIND_I2X, 64'h0, 16'h0, 64'h0, 1'b1, 1'b1, '0);
      add_row(KIND_I2X, 64'h1, 16'h0, 64'h0, 1'b1, 1'b1,
              '{64'd0, 16'hbfff, 64'h8000_0000_0000_0000, 1'b0, 1'b0});
      add_row(KIND_I2X, 64'hffff_ffff_ffff_ffff, 16'h0, 64'h0, 1'b0, 1'b0, none);
      add_row(3'd6, 64'hffff_ffff_ffff_ffff, 16'hffff, 64'hffff_ffff_ffff_ffff, 1'b1, 1'b1,
              '0);
      add_row(3'd7, 64'h1, 16'h3fff, 64'h1, 1'b1, 1'b1, '0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int md = 0; md < 4; md++) begin
         if (md != 0) set_mode(2'(md));
         foreach (vectors[i]) begin
            want = vectors[i].known ? vectors[i].want : convert(vectors[i].req, 2'(md));
            if (convert(vectors[i].req, 2'(md)) !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("vector %0d disagrees with predictor", i);
            end
            send(vectors[i].req, md[0]);
         end
         drain();
      end

      for (int phase = 0; phase < 8; phase++) begin
         set_mode((phase < 4) ? 2'($urandom_range(0, 3)) : 2'(phase - 4));
         for (int n = 0; n < 200; n++) send(random_request(), phase < 6);
         drain();
      end

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
